@@ rtl/core/sps_pkg.sv @@
// Shared types and constants for the servo pulse sequencer with slew.
// Used by every module of the block; depends on nothing else.
package sps_pkg;

	localparam int NUM_CHANNELS = 12;
	localparam int CNT_BITS     = 16;
	localparam int WIDTH_BITS   = 16;
	localparam int RATE_BITS    = 8;
	localparam int CH_BITS      = 4;
	localparam int USED_BITS    = 4;
	localparam int GUARD_BITS   = 8;
	localparam int SLOT_BITS    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int CFG_DATA_BITS = 16;

	localparam logic [WIDTH_BITS-1:0] DEFAULT_WIDTH = WIDTH_BITS'(3000);
	localparam logic [CNT_BITS-1:0]   REFRESH_RESET = CNT_BITS'(40000);
	localparam logic [GUARD_BITS-1:0] GUARD_RESET   = GUARD_BITS'(4);

	typedef enum logic [1:0] {
		ACT_TICK = 2'd0,
		ACT_SET  = 2'd1,
		ACT_MOVE = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		REG_ACTIVE_MASK   = 2'd0,
		REG_CHANNELS_USED = 2'd1,
		REG_REFRESH_TICKS = 2'd2,
		REG_GUARD_TICKS   = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [1:0]            action;
		logic [CH_BITS-1:0]    channel;
		logic [WIDTH_BITS-1:0] position_ticks;
		logic [RATE_BITS-1:0]  speed;
	} req_t;

	typedef struct packed {
		logic [NUM_CHANNELS-1:0] pulse_levels;
		logic [WIDTH_BITS-1:0]   width_readback;
		logic                    moving;
	} rsp_t;

	typedef struct packed {
		logic [NUM_CHANNELS-1:0] active_mask;
		logic [USED_BITS-1:0]    channels_used;
		logic [CNT_BITS-1:0]     refresh_ticks;
		logic [GUARD_BITS-1:0]   guard_ticks;
	} cfg_t;

	typedef struct packed {
		logic                  start;
		logic                  load;
		logic                  set_now;
		logic [WIDTH_BITS-1:0] pos;
		logic [RATE_BITS-1:0]  spd;
	} lane_cmd_t;

	typedef struct packed {
		logic [WIDTH_BITS-1:0] width;
		logic                  moving;
	} lane_stat_t;

endpackage

@@ rtl/core/servo_pulse_sequencer_slew.sv @@
// Top level of the servo pulse sequencer with per-channel slew.
// Instantiates sps_seq and one sps_lane per channel; depends on sps_pkg.
//
// Each request item is a timer tick, a set-position or a move-with-speed
// command, and yields one response item carrying all output levels plus the
// width and slewing flag of the addressed channel. One item is taken every
// clock cycle while req_stall is low; each item is held in the input register
// and then in the response register, with the whole update between them. A
// stalled response holds back new items only once the input register is full
// as well. Configuration writes are always ready and take effect at once;
// they are meant to be made while no item is in flight.
module servo_pulse_sequencer_slew import sps_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_stall,
	input  req_t                     req,
	output logic                     rsp_valid,
	input  logic                     rsp_stall,
	output rsp_t                     rsp,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [1:0]               cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	req_t                    req_s1;
	logic                    valid_s1;
	rsp_t                    rsp_q, rsp_nxt;
	logic                    rsp_valid_q;
	logic                    rsp_free, adv, step, is_set, is_move, ch_ok;
	cfg_t                    cfg_q;
	lane_cmd_t               lane_cmd  [NUM_CHANNELS];
	lane_stat_t              lane_stat [NUM_CHANNELS];
	logic [WIDTH_BITS-1:0]   lane_width [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] start, levels_nxt;

	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign adv       = valid_s1 && rsp_free;
	assign req_stall = valid_s1 && !rsp_free;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (!req_stall) begin
				valid_s1 <= req_valid;
			end
			if (rsp_free) begin
				rsp_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
		if (adv) begin
			rsp_q <= rsp_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_mask   <= '0;
			cfg_q.channels_used <= '0;
			cfg_q.refresh_ticks <= REFRESH_RESET;
			cfg_q.guard_ticks   <= GUARD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ACTIVE_MASK:   cfg_q.active_mask   <= NUM_CHANNELS'(cfg_data);
				REG_CHANNELS_USED: cfg_q.channels_used <= cfg_data[USED_BITS-1:0];
				REG_REFRESH_TICKS: cfg_q.refresh_ticks <= CNT_BITS'(cfg_data);
				REG_GUARD_TICKS:   cfg_q.guard_ticks   <= cfg_data[GUARD_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	assign step    = adv && (req_s1.action == ACT_TICK);
	assign is_set  = (req_s1.action == ACT_SET) ||
		((req_s1.action == ACT_MOVE) && (req_s1.speed == '0));
	assign is_move = (req_s1.action == ACT_MOVE);
	assign ch_ok   = req_s1.channel < CH_BITS'(NUM_CHANNELS);

	for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_lane
		assign lane_cmd[i].start   = start[i];
		assign lane_cmd[i].load    = adv && (is_set || is_move) &&
			(req_s1.channel == CH_BITS'(i));
		assign lane_cmd[i].set_now = is_set;
		assign lane_cmd[i].pos     = req_s1.position_ticks;
		assign lane_cmd[i].spd     = req_s1.speed;
		assign lane_width[i]       = lane_stat[i].width;

		sps_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (lane_cmd[i]),
			.stat   (lane_stat[i])
		);
	end

	sps_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.cfg        (cfg_q),
		.lane_width (lane_width),
		.start      (start),
		.levels_nxt (levels_nxt)
	);

	always_comb begin
		rsp_nxt.pulse_levels   = levels_nxt;
		rsp_nxt.width_readback = '0;
		rsp_nxt.moving         = 1'b0;
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			if (ch_ok && (req_s1.channel == CH_BITS'(i))) begin
				rsp_nxt.width_readback = lane_stat[i].width;
				rsp_nxt.moving         = lane_stat[i].moving;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ rtl/core/sps_lane.sv @@
// One servo channel: present width, target width and slew rate.
// Applies set and move commands and one slew step when its pulse starts.
// Depends on sps_pkg.
module sps_lane import sps_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  lane_cmd_t  cmd,
	output lane_stat_t stat
);

	logic [WIDTH_BITS-1:0] width_q, target_q, width_n, target_n;
	logic [RATE_BITS-1:0]  rate_q, rate_n;
	logic [WIDTH_BITS-1:0] rate_ext;
	logic [WIDTH_BITS:0]   sum_up, sum_dn;

	assign rate_ext = WIDTH_BITS'(rate_q);
	assign sum_up   = {1'b0, width_q} + {1'b0, rate_ext};
	assign sum_dn   = {1'b0, target_q} + {1'b0, rate_ext};

	always_comb begin
		width_n  = width_q;
		target_n = target_q;
		rate_n   = rate_q;
		if (cmd.start && (rate_q != '0)) begin
			if (target_q > width_q) begin
				if ({1'b0, target_q} <= sum_up) begin
					width_n = target_q;
					rate_n  = '0;
				end else begin
					width_n = sum_up[WIDTH_BITS-1:0];
				end
			end else begin
				if ({1'b0, width_q} <= sum_dn) begin
					width_n = target_q;
					rate_n  = '0;
				end else begin
					width_n = width_q - rate_ext;
				end
			end
		end
		if (cmd.load) begin
			target_n = cmd.pos;
			if (cmd.set_now) begin
				width_n = cmd.pos;
				rate_n  = '0;
			end else begin
				rate_n = cmd.spd;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DEFAULT_WIDTH;
			target_q <= '0;
			rate_q   <= '0;
		end else begin
			width_q  <= width_n;
			target_q <= target_n;
			rate_q   <= rate_n;
		end
	end

	assign stat.width  = width_n;
	assign stat.moving = (rate_n != '0);

endmodule

@@ rtl/core/sps_seq.sv @@
// Frame sequencer: tick counter, compare value, running slot and output levels.
// Starts each channel's pulse in turn and closes the frame. Depends on sps_pkg.
module sps_seq import sps_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  cfg_t                    cfg,
	input  logic [WIDTH_BITS-1:0]   lane_width [NUM_CHANNELS],
	output logic [NUM_CHANNELS-1:0] start,
	output logic [NUM_CHANNELS-1:0] levels_nxt
);

	logic [CNT_BITS-1:0]     counter_q, compare_q, base, compare_nxt;
	logic [SLOT_BITS-1:0]    slot_q;
	logic                    idle_q;
	logic [NUM_CHANNELS-1:0] levels_q;
	logic [USED_BITS-1:0]    used;
	logic [SLOT_BITS:0]      nxt_slot;
	logic                    in_frame, fire;
	logic [WIDTH_BITS-1:0]   sel_width;
	logic [CNT_BITS:0]       ahead;

	assign used     = (cfg.channels_used > USED_BITS'(NUM_CHANNELS)) ?
		USED_BITS'(NUM_CHANNELS) : cfg.channels_used;
	assign base     = idle_q ? '0 : counter_q;
	assign nxt_slot = idle_q ? '0 : ({1'b0, slot_q} + (SLOT_BITS+1)'(1));
	assign in_frame = nxt_slot < (SLOT_BITS+1)'(used);
	assign fire     = step && (counter_q == compare_q);
	assign ahead    = {1'b0, base} + (CNT_BITS+1)'(cfg.guard_ticks);

	always_comb begin
		sel_width  = '0;
		levels_nxt = levels_q;
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			start[i] = fire && in_frame && (nxt_slot == (SLOT_BITS+1)'(i));
			if (nxt_slot == (SLOT_BITS+1)'(i)) begin
				sel_width = lane_width[i];
			end
			if (fire && !idle_q && (slot_q == SLOT_BITS'(i))) begin
				levels_nxt[i] = 1'b0;
			end
		end
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			if (start[i] && cfg.active_mask[i]) begin
				levels_nxt[i] = 1'b1;
			end
		end
		if (in_frame) begin
			compare_nxt = base + CNT_BITS'(sel_width);
		end else if (ahead < (CNT_BITS+1)'(cfg.refresh_ticks)) begin
			compare_nxt = cfg.refresh_ticks;
		end else begin
			compare_nxt = ahead[CNT_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
			compare_q <= '0;
			slot_q    <= '0;
			idle_q    <= 1'b1;
			levels_q  <= '0;
		end else if (step) begin
			levels_q <= levels_nxt;
			if (fire) begin
				counter_q <= base + CNT_BITS'(1);
				compare_q <= compare_nxt;
				if (in_frame) begin
					slot_q <= nxt_slot[SLOT_BITS-1:0];
					idle_q <= 1'b0;
				end else begin
					idle_q <= 1'b1;
				end
			end else begin
				counter_q <= counter_q + CNT_BITS'(1);
			end
		end
	end

endmodule

@@ tb/sps_response_checker.sv @@
// Checker for the servo pulse sequencer: watches the request, response and
// configuration channels, predicts every response and compares it field by field.
// Depends on sps_pkg for the item, response and register types.
module sps_response_checker import sps_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	input  logic                     req_stall,
	input  req_t                     req,
	input  logic                     rsp_valid,
	input  logic                     rsp_stall,
	input  rsp_t                     rsp,
	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  logic [1:0]               cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	output int                       fail_count,
	output int                       responses_due,
	output int                       responses_checked,
	output int                       pulses_started,
	output int                       slews_arrived
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [NUM_CHANNELS-1:0] mask_cfg;
	logic [USED_BITS-1:0]    used_cfg;
	logic [CNT_BITS-1:0]     refresh_cfg;
	logic [GUARD_BITS-1:0]   guard_cfg;

	logic [CNT_BITS-1:0]     tick_count;
	logic [CNT_BITS-1:0]     match_at;
	int                      slot;
	logic [WIDTH_BITS-1:0]   width_now [NUM_CHANNELS];
	logic [WIDTH_BITS-1:0]   width_goal [NUM_CHANNELS];
	logic [RATE_BITS-1:0]    step_size [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] levels;

	rsp_t expected_rsp [$];
	rsp_t want;

	function automatic void slew_toward(int ch);
		logic [WIDTH_BITS:0] w, t, s;
		w = width_now[ch];
		t = width_goal[ch];
		s = step_size[ch];
		if (s == 0)
			return;
		if (t > w) begin
			if (t <= w + s) begin
				width_now[ch] = t[WIDTH_BITS-1:0];
				step_size[ch] = '0;
				slews_arrived++;
			end else begin
				width_now[ch] = WIDTH_BITS'(w + s);
			end
		end else if (w <= t + s) begin
			width_now[ch] = t[WIDTH_BITS-1:0];
			step_size[ch] = '0;
			slews_arrived++;
		end else begin
			width_now[ch] = WIDTH_BITS'(w - s);
		end
	endfunction

	function automatic void next_slot();
		int                used;
		logic [CNT_BITS:0] ahead;
		used = (used_cfg > NUM_CHANNELS) ? NUM_CHANNELS : int'(used_cfg);
		if (slot < 0)
			tick_count = '0;
		else if (slot < NUM_CHANNELS)
			levels[slot] = 1'b0;
		slot++;
		if (slot < used) begin
			slew_toward(slot);
			match_at = tick_count + width_now[slot];
			if (mask_cfg[slot]) begin
				levels[slot] = 1'b1;
				pulses_started++;
			end
		end else begin
			ahead = {1'b0, tick_count} + guard_cfg;
			if (ahead < refresh_cfg)
				match_at = refresh_cfg;
			else
				match_at = ahead[CNT_BITS-1:0];
			slot = -1;
		end
	endfunction

	function automatic rsp_t sequencer_step(req_t r);
		rsp_t o;
		logic in_range;
		in_range = r.channel < NUM_CHANNELS;
		if (r.action == ACT_TICK) begin
			if (tick_count == match_at)
				next_slot();
			tick_count = tick_count + 1'b1;
		end else if (r.action == ACT_SET || (r.action == ACT_MOVE && r.speed == '0)) begin
			if (in_range) begin
				width_now[r.channel] = r.position_ticks;
				width_goal[r.channel] = r.position_ticks;
				step_size[r.channel] = '0;
			end
		end else if (r.action == ACT_MOVE) begin
			if (in_range) begin
				width_goal[r.channel] = r.position_ticks;
				step_size[r.channel] = r.speed;
			end
		end
		o.pulse_levels = levels;
		o.width_readback = in_range ? width_now[r.channel] : '0;
		o.moving = in_range ? (step_size[r.channel] != '0) : 1'b0;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_cfg = '0;
			used_cfg = '0;
			refresh_cfg = REFRESH_RESET;
			guard_cfg = GUARD_RESET;
			tick_count = '0;
			match_at = '0;
			slot = -1;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				width_now[i] = DEFAULT_WIDTH;
				width_goal[i] = '0;
				step_size[i] = '0;
			end
			levels = '0;
			expected_rsp.delete();
			fail_count = 0;
			responses_due = 0;
			responses_checked = 0;
			pulses_started = 0;
			slews_arrived = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp.size() == 0) begin
					$error("response item arrived with none expected");
					fail_count++;
				end else begin
					want = expected_rsp.pop_front();
					responses_checked++;
					if (rsp.pulse_levels !== want.pulse_levels) begin
						$error("pulse_levels: expected %h, got %h",
							want.pulse_levels, rsp.pulse_levels);
						fail_count++;
					end
					if (rsp.width_readback !== want.width_readback) begin
						$error("width_readback: expected %0d, got %0d",
							want.width_readback, rsp.width_readback);
						fail_count++;
					end
					if (rsp.moving !== want.moving) begin
						$error("moving: expected %b, got %b", want.moving, rsp.moving);
						fail_count++;
					end
				end
			end
			if (req_valid && !req_stall)
				expected_rsp.push_back(sequencer_step(req));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ACTIVE_MASK:   mask_cfg = cfg_data[NUM_CHANNELS-1:0];
					REG_CHANNELS_USED: used_cfg = cfg_data[USED_BITS-1:0];
					REG_REFRESH_TICKS: refresh_cfg = cfg_data[CNT_BITS-1:0];
					REG_GUARD_TICKS:   guard_cfg = cfg_data[GUARD_BITS-1:0];
					default:           ;
				endcase
			end
			responses_due = expected_rsp.size();
		end
	end

endmodule

@@ tb/servo_pulse_sequencer_slew_tb.sv @@
// Top of the servo pulse sequencer testbench: clock, reset, stimulus and verdict.
// Depends on sps_pkg, the block servo_pulse_sequencer_slew and sps_response_checker.
module servo_pulse_sequencer_slew_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sps_pkg::*;

	localparam logic [1:0] ACT_NONE = 2'd3;
	localparam int IDLE_LIMIT   = 1000;
	localparam int RANDOM_ITEMS = 200;
	localparam int SMALL_WIDTH  = 24;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     req_valid = 1'b0;
	logic                     req_stall;
	req_t                     req = '0;
	logic                     rsp_valid;
	logic                     rsp_stall = 1'b0;
	rsp_t                     rsp;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [1:0]               cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	int fail_count, responses_due, responses_checked, pulses_started, slews_arrived;
	int gap_pct = 0;
	int stall_pct = 0;
	int idle_cycles = 0;
	int items_sent = 0;
	int phases_run = 0;

	servo_pulse_sequencer_slew i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	sps_response_checker i_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.req_valid         (req_valid),
		.req_stall         (req_stall),
		.req               (req),
		.rsp_valid         (rsp_valid),
		.rsp_stall         (rsp_stall),
		.rsp               (rsp),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.fail_count        (fail_count),
		.responses_due     (responses_due),
		.responses_checked (responses_checked),
		.pulses_started    (pulses_started),
		.slews_arrived     (slews_arrived)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic req_t item_of(logic [1:0] act, logic [CH_BITS-1:0] ch,
			logic [WIDTH_BITS-1:0] pos, logic [RATE_BITS-1:0] spd);
		req_t r;
		r.action = act;
		r.channel = ch;
		r.position_ticks = pos;
		r.speed = spd;
		return r;
	endfunction

	// Channels that take part in frames get short widths so that frames keep turning over.
	function automatic req_t random_item(int used);
		req_t r;
		int   pick;
		pick = $urandom_range(99);
		r.channel = CH_BITS'($urandom_range(15));
		r.position_ticks = WIDTH_BITS'($urandom);
		r.speed = RATE_BITS'($urandom);
		if (pick < 70)
			r.action = ACT_TICK;
		else if (pick < 82)
			r.action = ACT_SET;
		else if (pick < 95)
			r.action = ACT_MOVE;
		else
			r.action = ACT_NONE;
		if (r.action == ACT_SET || r.action == ACT_MOVE) begin
			if ($urandom_range(9) != 0)
				r.channel = CH_BITS'($urandom_range(NUM_CHANNELS - 1));
			if (r.channel < used)
				r.position_ticks = WIDTH_BITS'($urandom_range(SMALL_WIDTH, 1));
		end
		return r;
	endfunction

	task automatic send(input req_t item);
		while ($urandom_range(99) < gap_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		items_sent++;
	endtask

	// The checker's count is read at the falling edge, once it has settled.
	task automatic wait_idle();
		req_valid <= 1'b0;
		@(negedge clk);
		while (responses_due != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic apply_settings(input cfg_t s);
		wait_idle();
		write_reg(REG_ACTIVE_MASK, CFG_DATA_BITS'(s.active_mask));
		write_reg(REG_CHANNELS_USED, CFG_DATA_BITS'(s.channels_used));
		write_reg(REG_REFRESH_TICKS, CFG_DATA_BITS'(s.refresh_ticks));
		write_reg(REG_GUARD_TICKS, CFG_DATA_BITS'(s.guard_ticks));
		cfg_valid <= 1'b0;
		phases_run++;
	endtask

	task automatic set_idling(input int mode);
		case (mode)
			1:       begin gap_pct = 59; stall_pct = 0; end
			2:       begin gap_pct = 0; stall_pct = 59; end
			3:       begin gap_pct = 11; stall_pct = 11; end
			default: begin gap_pct = 0; stall_pct = 0; end
		endcase
	endtask

	task automatic run_phase(input cfg_t s, input int mode);
		int used;
		used = (s.channels_used > NUM_CHANNELS) ? NUM_CHANNELS : int'(s.channels_used);
		apply_settings(s);
		set_idling(mode);
		for (int ch = 0; ch < NUM_CHANNELS; ch++)
			send(item_of(ACT_SET, CH_BITS'(ch),
				WIDTH_BITS'($urandom_range(SMALL_WIDTH, 1)), '0));
		repeat (RANDOM_ITEMS) send(random_item(used));
	endtask

	initial begin
		cfg_t plan [6];
		plan[0] = '{12'hFFF, 4'd12, 16'd64, 8'd4};
		plan[1] = '{12'($urandom), 4'd5, 16'd20, 8'd1};
		plan[2] = '{12'h000, 4'd0, 16'd1, 8'd255};
		plan[3] = '{12'($urandom), 4'd15, 16'd30, 8'd255};
		plan[4] = '{12'($urandom), 4'd1, 16'd100, 8'd8};
		plan[5] = '{12'($urandom), 4'd12, 16'd65535, 8'd128};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		apply_settings('{12'hFFF, 4'd2, 16'd40, 8'd2});
		send(item_of(ACT_SET, 4'd0, 16'h0000, 8'h00));
		send(item_of(ACT_SET, 4'd0, 16'hFFFF, 8'hFF));
		send(item_of(ACT_MOVE, 4'd1, 16'hFFFF, 8'h00));
		send(item_of(ACT_MOVE, 4'd1, 16'h0000, 8'hFF));
		send(item_of(ACT_SET, 4'd12, 16'h1234, 8'h00));
		send(item_of(ACT_MOVE, 4'd15, 16'hAAAA, 8'h55));
		send(item_of(ACT_NONE, 4'd3, 16'h5555, 8'hAA));
		send(item_of(ACT_SET, 4'd11, 16'hFFFF, 8'h01));
		// Slews that overshoot upwards and downwards are loaded; the upward one clamps at the target.
		send(item_of(ACT_SET, 4'd0, 16'd10, 8'h00));
		send(item_of(ACT_MOVE, 4'd0, 16'd20, 8'hFF));
		send(item_of(ACT_SET, 4'd1, 16'd200, 8'h00));
		send(item_of(ACT_MOVE, 4'd1, 16'd1, 8'hFF));
		for (int i = 0; i < 12; i++)
			send(item_of(ACT_TICK, CH_BITS'(i % 2), WIDTH_BITS'($urandom),
				RATE_BITS'($urandom)));

		for (int p = 0; p < 5; p++)
			run_phase(plan[p], p % 4);

		// A slew whose sum no longer fits the width field; the frame stalls afterwards,
		// so the long refresh phase comes last.
		apply_settings('{12'h001, 4'd1, 16'd40, 8'd4});
		set_idling(3);
		send(item_of(ACT_SET, 4'd0, 16'd65400, 8'h00));
		send(item_of(ACT_MOVE, 4'd0, 16'd65535, 8'hFF));
		repeat (300) send(item_of(ACT_TICK, 4'd0, WIDTH_BITS'($urandom), RATE_BITS'($urandom)));

		run_phase(plan[5], 1);

		wait_idle();
		$display("Ran %0d items through %0d register settings; %0d responses checked.",
			items_sent, phases_run, responses_checked);
		$display("Saw %0d channel pulses start and %0d slews reach their target.",
			pulses_started, slews_arrived);
		if (fail_count == 0 && responses_due == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
